// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define LKI_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define LKI_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/lki_pkg.sv -----
// ----------------------------------------------------------------------------
// lki_pkg
// Types, constants and codes for the looping keyframe interpolator.
// ----------------------------------------------------------------------------
package lki_pkg;

    localparam int MAX_KEYFRAMES = 16;
    localparam int ADDR_W        = $clog2(MAX_KEYFRAMES);
    localparam int CNT_W         = $clog2(MAX_KEYFRAMES + 1);

    localparam int TIME_W   = 16;
    localparam int VAL_W    = 16;
    localparam int SEG_W    = 4;
    localparam int STATUS_W = 2;

    // value * weight products and their sums
    localparam int PROD_W = 2 * VAL_W + 1;
    // magnitude of a sum, dividend of the serial divider
    localparam int MAG_W  = 2 * VAL_W;
    localparam int STEP_W = $clog2(MAG_W + 1);

    localparam logic [STEP_W-1:0] STEPS_MOD  = STEP_W'(TIME_W);
    localparam logic [STEP_W-1:0] STEPS_LERP = STEP_W'(MAG_W);

    localparam int MSTEP_W = 3;
    localparam logic [MSTEP_W-1:0] MUL_LAST = 3'd4;

    localparam logic [TIME_W-1:0] LOOP_RESET = 16'hFFFF;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HOLD  = 2'd3;

    // result kinds selected by the controller
    localparam int RES_W = 3;
    localparam logic [RES_W-1:0] RES_INSERT = 3'd0;
    localparam logic [RES_W-1:0] RES_FULL   = 3'd1;
    localparam logic [RES_W-1:0] RES_EMPTY  = 3'd2;
    localparam logic [RES_W-1:0] RES_HOLD   = 3'd3;
    localparam logic [RES_W-1:0] RES_LERP   = 3'd4;

    typedef struct packed {
        logic                     mode;
        logic [TIME_W-1:0]        time_point;
        logic signed [VAL_W-1:0]  angle_in;
        logic signed [VAL_W-1:0]  y_in;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [VAL_W-1:0]  rotation_out;
        logic signed [VAL_W-1:0]  y_out;
        logic [SEG_W-1:0]         segment_index;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0]        key_time;
        logic signed [VAL_W-1:0]  angle;
        logic signed [VAL_W-1:0]  height;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MOD_WAIT,
        S_SCAN_RD,
        S_SCAN_CK,
        S_SCAN_DONE,
        S_LAST_RD,
        S_LAST_CK,
        S_SPAN,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE_NEW
    } t_state;

    typedef struct packed {
        logic             load;
        logic             scan_init;
        logic             scan_rd;
        logic             scan_ck;
        logic             last_rd;
        logic             last_ck;
        logic             mod_start;
        logic             mod_load;
        logic             span;
        logic             mul_go;
        logic             div_start;
        logic             shift_init;
        logic             shift_rd;
        logic             shift_wr;
        logic             write_new;
        logic             emit;
        logic [RES_W-1:0] res_kind;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic full;
        logic loop_zero;
        logic is_query;
        logic scan_end;
        logic later;
        logic k_zero;
        logic shift_end;
        logic mul_last;
        logic div_done;
    } t_stat;

endpackage

// ----- hw/rtl/looping_keyframe_interpolator.sv -----
// ----------------------------------------------------------------------------
// looping_keyframe_interpolator
// Sorted keyframe table with looping, linearly interpolated pose queries.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel: drive i_item and raise start; the item is taken at a clock
//   edge where start is high and busy is low. mode 0 inserts a keyframe, mode
//   1 queries the pose at time_point (wrapped by the loop length).
//   Result channel: one item per input item, shown on o_res for a single
//   cycle with o_res_valid high, in the same cycle that busy drops. There is no
//   back-pressure; capture it then. A new item can be taken in that cycle.
//   Config channel: i_cfg_valid/o_cfg_ready write loop_length (always ready).
//   Write it only while busy is low.
// Sequence (each scan entry takes a registered read of the keyframe RAM):
//   insert: scan, then shift the later entries up and write the new key;
//   a full table drops the insert after the scan. query: an empty table
//   gives ST_EMPTY without a scan; otherwise the time is reduced modulo the
//   loop length on the serial divider (skipped for loop length 0), then the
//   scan runs; past the last key its values are held, else 4 multiplies run
//   on one shared multiplier, then a 32-step divide runs on two dividers
//   side by side (angle and height).
// Reset: table empty, loop_length 65535, no result pending. The keyframe
//   RAM is not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
module looping_keyframe_interpolator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item in
    input  logic                          start,
    output logic                          busy,
    input  lki_pkg::t_in                  i_item,
    // result out
    output logic                          o_res_valid,
    output lki_pkg::t_out                 o_res,
    // loop length register
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lki_pkg::TIME_W-1:0]    i_cfg_data
);

    lki_pkg::t_cmd  w_cmd;
    lki_pkg::t_stat w_stat;
    logic           w_cfg_we;

    // the user writes the register between items; the block does not enforce it, and the port never stalls
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;

    lki_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    lki_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_item      (i_item),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

// ----- hw/rtl/lki_ram.sv -----
// ----------------------------------------------------------------------------
// lki_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lki_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/lki_div.sv -----
// ----------------------------------------------------------------------------
// lki_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend is
// left-aligned, so a short run gives the remainder of its top bits.
// ----------------------------------------------------------------------------
module lki_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lki_pkg::MAG_W-1:0]        i_dividend,
    input  logic [lki_pkg::TIME_W-1:0]       i_divisor,
    input  logic [lki_pkg::STEP_W-1:0]       i_steps,
    output logic                             o_done,
    output logic [lki_pkg::MAG_W-1:0]        o_quotient,
    output logic [lki_pkg::TIME_W-1:0]       o_remainder
);

    logic                          r_busy;
    logic [lki_pkg::STEP_W-1:0]    r_cnt;
    logic [lki_pkg::MAG_W-1:0]     r_dvd;
    logic [lki_pkg::TIME_W-1:0]    r_rem;
    logic [lki_pkg::TIME_W-1:0]    r_dsr;

    logic [lki_pkg::TIME_W:0]      w_trial;
    logic [lki_pkg::TIME_W:0]      w_diff;
    logic                          w_ge;

    assign w_trial = {r_rem, r_dvd[lki_pkg::MAG_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - lki_pkg::STEP_W'(1);
            if (r_cnt == lki_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[lki_pkg::TIME_W-1:0] : w_trial[lki_pkg::TIME_W-1:0];
            r_dvd <= {r_dvd[lki_pkg::MAG_W-2:0], w_ge};
        end
    end

    assign o_done      = !r_busy;
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;

endmodule

// ----- hw/rtl/lki_dp.sv -----
// ----------------------------------------------------------------------------
// lki_dp
// Datapath: keyframe RAM, scan registers, shared multiplier, two serial
// dividers, loop length register and the result register.
// ----------------------------------------------------------------------------
module lki_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lki_pkg::t_cmd                 i_cmd,
    output lki_pkg::t_stat                o_stat,
    input  lki_pkg::t_in                  i_item,
    input  logic                          i_cfg_we,
    input  logic [lki_pkg::TIME_W-1:0]    i_cfg_data,
    output logic                          o_res_valid,
    output lki_pkg::t_out                 o_res
);

    // latched item
    logic                                r_mode;
    logic [lki_pkg::TIME_W-1:0]          r_t;
    logic signed [lki_pkg::VAL_W-1:0]    r_ang_in;
    logic signed [lki_pkg::VAL_W-1:0]    r_y_in;

    logic [lki_pkg::TIME_W-1:0]          r_loop;
    logic [lki_pkg::CNT_W-1:0]           r_count;
    logic [lki_pkg::CNT_W-1:0]           r_idx;
    logic [lki_pkg::CNT_W-1:0]           r_j;

    lki_pkg::t_key                       r_prev;
    lki_pkg::t_key                       r_cur;

    logic [lki_pkg::TIME_W-1:0]          r_w0;
    logic [lki_pkg::TIME_W-1:0]          r_w1;
    logic [lki_pkg::TIME_W-1:0]          r_span;

    logic [lki_pkg::MSTEP_W-1:0]         r_mstep;
    logic signed [lki_pkg::PROD_W-1:0]   r_prod;
    logic signed [lki_pkg::PROD_W-1:0]   r_num_a;
    logic signed [lki_pkg::PROD_W-1:0]   r_num_y;

    logic                                r_res_valid;
    lki_pkg::t_out                       r_res;

    logic [lki_pkg::KEY_W-1:0]           w_rdata_raw;
    lki_pkg::t_key                       w_rdata;
    logic                                w_re;
    logic [lki_pkg::ADDR_W-1:0]          w_raddr;
    logic                                w_we;
    logic [lki_pkg::ADDR_W-1:0]          w_waddr;
    lki_pkg::t_key                       w_wdata;
    logic [lki_pkg::CNT_W-1:0]           w_cnt_m1;
    logic [lki_pkg::CNT_W-1:0]           w_j_m1;

    logic signed [lki_pkg::VAL_W-1:0]    w_op_v;
    logic [lki_pkg::TIME_W-1:0]          w_op_w;
    logic signed [lki_pkg::PROD_W-1:0]   w_prod;

    logic [lki_pkg::MAG_W-1:0]           w_mag_a;
    logic [lki_pkg::MAG_W-1:0]           w_mag_y;
    logic                                w_d0_start;
    logic [lki_pkg::MAG_W-1:0]           w_d0_dvd;
    logic [lki_pkg::TIME_W-1:0]          w_d0_dsr;
    logic [lki_pkg::STEP_W-1:0]          w_d0_steps;
    logic                                w_d0_done;
    logic                                w_d1_done;
    logic [lki_pkg::MAG_W-1:0]           w_q0;
    logic [lki_pkg::MAG_W-1:0]           w_q1;
    logic [lki_pkg::TIME_W-1:0]          w_rem0;
    logic signed [lki_pkg::VAL_W-1:0]    w_rot;
    logic signed [lki_pkg::VAL_W-1:0]    w_yv;
    lki_pkg::t_out                       n_res;

    // ---------------- keyframe store ----------------
    assign w_cnt_m1 = r_count - lki_pkg::CNT_W'(1);
    assign w_j_m1   = r_j - lki_pkg::CNT_W'(1);
    assign w_rdata  = lki_pkg::t_key'(w_rdata_raw);

    always_comb begin
        w_re = i_cmd.scan_rd | i_cmd.last_rd | i_cmd.shift_rd;
        if (i_cmd.last_rd) begin
            w_raddr = w_cnt_m1[lki_pkg::ADDR_W-1:0];
        end else if (i_cmd.shift_rd) begin
            w_raddr = w_j_m1[lki_pkg::ADDR_W-1:0];
        end else begin
            w_raddr = r_idx[lki_pkg::ADDR_W-1:0];
        end
        w_we = i_cmd.shift_wr | i_cmd.write_new;
        if (i_cmd.shift_wr) begin
            w_waddr = r_j[lki_pkg::ADDR_W-1:0];
            w_wdata = w_rdata;
        end else begin
            w_waddr = r_idx[lki_pkg::ADDR_W-1:0];
            w_wdata = '{key_time: r_t, angle: r_ang_in, height: r_y_in};
        end
    end

    lki_ram #(
        .WIDTH (lki_pkg::KEY_W),
        .DEPTH (lki_pkg::MAX_KEYFRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    // ---------------- shared multiplier ----------------
    // num = v0 * (t1 - t) + v1 * (t - t0), angle then height
    always_comb begin
        case (r_mstep)
            3'd0: begin
                w_op_v = r_prev.angle;
                w_op_w = r_w0;
            end
            3'd1: begin
                w_op_v = r_cur.angle;
                w_op_w = r_w1;
            end
            3'd2: begin
                w_op_v = r_prev.height;
                w_op_w = r_w0;
            end
            default: begin
                w_op_v = r_cur.height;
                w_op_w = r_w1;
            end
        endcase
        w_prod = lki_pkg::PROD_W'(w_op_v) * lki_pkg::PROD_W'($signed({1'b0, w_op_w}));
    end

    // ---------------- dividers ----------------
    assign w_mag_a = r_num_a[lki_pkg::PROD_W-1] ? lki_pkg::MAG_W'(-r_num_a)
                                                 : lki_pkg::MAG_W'(r_num_a);
    assign w_mag_y = r_num_y[lki_pkg::PROD_W-1] ? lki_pkg::MAG_W'(-r_num_y)
                                                 : lki_pkg::MAG_W'(r_num_y);

    // divider 0 also reduces the query time by the loop length
    always_comb begin
        w_d0_start = i_cmd.mod_start | i_cmd.div_start;
        if (i_cmd.mod_start) begin
            w_d0_dvd   = {r_t, {(lki_pkg::MAG_W - lki_pkg::TIME_W){1'b0}}};
            w_d0_dsr   = r_loop;
            w_d0_steps = lki_pkg::STEPS_MOD;
        end else begin
            w_d0_dvd   = w_mag_a;
            w_d0_dsr   = r_span;
            w_d0_steps = lki_pkg::STEPS_LERP;
        end
    end

    lki_div u_div0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_d0_start),
        .i_dividend  (w_d0_dvd),
        .i_divisor   (w_d0_dsr),
        .i_steps     (w_d0_steps),
        .o_done      (w_d0_done),
        .o_quotient  (w_q0),
        .o_remainder (w_rem0)
    );

    // height divide: only the quotient is needed
    lki_div u_div1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_mag_y),
        .i_divisor   (r_span),
        .i_steps     (lki_pkg::STEPS_LERP),
        .o_done      (w_d1_done),
        .o_quotient  (w_q1),
        .o_remainder ()
    );

    // truncation toward zero: divide magnitudes, restore sign
    assign w_rot = r_num_a[lki_pkg::PROD_W-1] ? -$signed(w_q0[lki_pkg::VAL_W-1:0])
                                               : $signed(w_q0[lki_pkg::VAL_W-1:0]);
    assign w_yv  = r_num_y[lki_pkg::PROD_W-1] ? -$signed(w_q1[lki_pkg::VAL_W-1:0])
                                               : $signed(w_q1[lki_pkg::VAL_W-1:0]);

    // ---------------- status to controller ----------------
    always_comb begin
        o_stat.cnt_zero  = (r_count == '0);
        o_stat.full      = (r_count == lki_pkg::CNT_W'(lki_pkg::MAX_KEYFRAMES));
        o_stat.loop_zero = (r_loop == '0);
        o_stat.is_query  = (r_mode == lki_pkg::MODE_QUERY);
        o_stat.scan_end  = (r_idx == r_count);
        o_stat.later     = (w_rdata.key_time > r_t);
        o_stat.k_zero    = (r_idx == '0);
        o_stat.shift_end = (r_j == r_idx);
        o_stat.mul_last  = (r_mstep == lki_pkg::MUL_LAST);
        o_stat.div_done  = w_d0_done & w_d1_done;
    end

    // ---------------- result ----------------
    always_comb begin
        n_res.status        = lki_pkg::ST_EMPTY;
        n_res.rotation_out  = '0;
        n_res.y_out         = '0;
        n_res.segment_index = '0;
        case (i_cmd.res_kind)
            lki_pkg::RES_INSERT: begin
                n_res.status        = lki_pkg::ST_OK;
                n_res.segment_index = lki_pkg::SEG_W'(r_idx);
            end
            lki_pkg::RES_FULL: begin
                n_res.status        = lki_pkg::ST_FULL;
                n_res.segment_index = lki_pkg::SEG_W'(r_idx);
            end
            lki_pkg::RES_HOLD: begin
                n_res.status        = lki_pkg::ST_HOLD;
                n_res.rotation_out  = r_prev.angle;
                n_res.y_out         = r_prev.height;
                n_res.segment_index = lki_pkg::SEG_W'(w_cnt_m1);
            end
            lki_pkg::RES_LERP: begin
                n_res.status        = lki_pkg::ST_OK;
                n_res.rotation_out  = w_rot;
                n_res.y_out         = w_yv;
                n_res.segment_index = lki_pkg::SEG_W'(r_idx);
            end
            default: begin
                n_res.status = lki_pkg::ST_EMPTY;
            end
        endcase
    end

    // ---------------- control-type registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop      <= lki_pkg::LOOP_RESET;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_loop <= i_cfg_data;
            end
            if (i_cmd.write_new) begin
                r_count <= r_count + lki_pkg::CNT_W'(1);
            end
            r_res_valid <= i_cmd.emit;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_item.mode;
            r_t      <= i_item.time_point;
            r_ang_in <= i_item.angle_in;
            r_y_in   <= i_item.y_in;
        end
        if (i_cmd.mod_load) begin
            r_t <= w_rem0;
        end
        if (i_cmd.scan_init) begin
            r_idx           <= '0;
            r_prev.key_time <= '0;
        end
        if (i_cmd.scan_ck) begin
            if (o_stat.later) begin
                r_cur <= w_rdata;
            end else begin
                r_prev <= w_rdata;
                r_idx  <= r_idx + lki_pkg::CNT_W'(1);
            end
        end
        // first segment: start point is time 0 with the last keyframe's values
        if (i_cmd.last_ck) begin
            r_prev.angle  <= w_rdata.angle;
            r_prev.height <= w_rdata.height;
        end
        if (i_cmd.span) begin
            r_w0    <= r_cur.key_time - r_t;
            r_w1    <= r_t - r_prev.key_time;
            r_span  <= r_cur.key_time - r_prev.key_time;
            r_mstep <= '0;
        end
        if (i_cmd.mul_go) begin
            r_mstep <= r_mstep + lki_pkg::MSTEP_W'(1);
            case (r_mstep)
                3'd0: begin
                    r_prod <= w_prod;
                end
                3'd1: begin
                    r_prod  <= w_prod;
                    r_num_a <= r_prod;
                end
                3'd2: begin
                    r_prod  <= w_prod;
                    r_num_a <= r_num_a + r_prod;
                end
                3'd3: begin
                    r_prod  <= w_prod;
                    r_num_y <= r_prod;
                end
                default: begin
                    r_num_y <= r_num_y + r_prod;
                end
            endcase
        end
        if (i_cmd.shift_init) begin
            r_j <= r_count;
        end
        if (i_cmd.shift_wr) begin
            r_j <= w_j_m1;
        end
        if (i_cmd.emit) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- hw/rtl/lki_ctrl.sv -----
// ----------------------------------------------------------------------------
// lki_ctrl
// Sequencer: walks one item through reduction, table scan, shifting or
// multiply and divide, and issues the result.
// ----------------------------------------------------------------------------
module lki_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  lki_pkg::t_stat  i_stat,
    output lki_pkg::t_cmd   o_cmd
);

    lki_pkg::t_state r_state;
    lki_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lki_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            lki_pkg::S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = lki_pkg::S_CHECK;
                end
            end
            lki_pkg::S_CHECK: begin
                o_cmd.scan_init = 1'b1;
                if (i_stat.is_query && i_stat.cnt_zero) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_kind = lki_pkg::RES_EMPTY;
                    n_state        = lki_pkg::S_IDLE;
                end else if (i_stat.is_query && !i_stat.loop_zero) begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = lki_pkg::S_MOD_WAIT;
                end else begin
                    n_state = lki_pkg::S_SCAN_RD;
                end
            end
            lki_pkg::S_MOD_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.mod_load = 1'b1;
                    n_state        = lki_pkg::S_SCAN_RD;
                end
            end
            lki_pkg::S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    n_state = lki_pkg::S_SCAN_DONE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = lki_pkg::S_SCAN_CK;
                end
            end
            lki_pkg::S_SCAN_CK: begin
                o_cmd.scan_ck = 1'b1;
                n_state = i_stat.later ? lki_pkg::S_SCAN_DONE : lki_pkg::S_SCAN_RD;
            end
            lki_pkg::S_SCAN_DONE: begin
                if (!i_stat.is_query) begin
                    if (i_stat.full) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.res_kind = lki_pkg::RES_FULL;
                        n_state        = lki_pkg::S_IDLE;
                    end else begin
                        o_cmd.shift_init = 1'b1;
                        n_state          = lki_pkg::S_SHIFT_RD;
                    end
                end else if (i_stat.scan_end) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_kind = lki_pkg::RES_HOLD;
                    n_state        = lki_pkg::S_IDLE;
                end else if (i_stat.k_zero) begin
                    n_state = lki_pkg::S_LAST_RD;
                end else begin
                    n_state = lki_pkg::S_SPAN;
                end
            end
            lki_pkg::S_LAST_RD: begin
                o_cmd.last_rd = 1'b1;
                n_state       = lki_pkg::S_LAST_CK;
            end
            lki_pkg::S_LAST_CK: begin
                o_cmd.last_ck = 1'b1;
                n_state       = lki_pkg::S_SPAN;
            end
            lki_pkg::S_SPAN: begin
                o_cmd.span = 1'b1;
                n_state    = lki_pkg::S_MUL;
            end
            lki_pkg::S_MUL: begin
                o_cmd.mul_go = 1'b1;
                if (i_stat.mul_last) begin
                    n_state = lki_pkg::S_DIV_START;
                end
            end
            lki_pkg::S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = lki_pkg::S_DIV_WAIT;
            end
            lki_pkg::S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_kind = lki_pkg::RES_LERP;
                    n_state        = lki_pkg::S_IDLE;
                end
            end
            lki_pkg::S_SHIFT_RD: begin
                if (i_stat.shift_end) begin
                    n_state = lki_pkg::S_WRITE_NEW;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = lki_pkg::S_SHIFT_WR;
                end
            end
            lki_pkg::S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = lki_pkg::S_SHIFT_RD;
            end
            lki_pkg::S_WRITE_NEW: begin
                o_cmd.write_new = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.res_kind  = lki_pkg::RES_INSERT;
                n_state         = lki_pkg::S_IDLE;
            end
            default: begin
                n_state = lki_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != lki_pkg::S_IDLE);

endmodule

// ----- hw/rtl/lki_checker.sv -----
// ----------------------------------------------------------------------------
// lki_checker
// Port-level checks of the keyframe interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lki_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_res_valid,
    input  lki_pkg::t_out                 o_res,
    input  logic                          o_cfg_ready
);

    logic w_no_pose_res;
    logic w_pose_zero;
    logic w_empty_res;

    assign w_no_pose_res = o_res_valid && (o_res.status == lki_pkg::ST_FULL ||
                                           o_res.status == lki_pkg::ST_EMPTY);
    assign w_pose_zero   = (o_res.rotation_out == '0) && (o_res.y_out == '0);
    assign w_empty_res   = o_res_valid && (o_res.status == lki_pkg::ST_EMPTY);

    // an accepted item raises busy in the following cycle
    `LKI_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accept without busy")

    // a result closes the item it belongs to
    `LKI_ASSERT(a_res_ends_item, i_clk, i_rst_n, o_res_valid |-> (!busy && $past(busy)), "stray result")

    // dropped insert and empty table carry no pose
    `LKI_ASSERT(a_zero_pose, i_clk, i_rst_n, w_no_pose_res |-> w_pose_zero, "pose on full or empty")

    // empty table reports segment zero
    `LKI_ASSERT(a_empty_seg, i_clk, i_rst_n, w_empty_res |-> (o_res.segment_index == '0), "segment on empty")

    // loop length port never stalls
    `LKI_ASSERT_ALWAYS(a_cfg_ready, i_clk, o_cfg_ready, "config not ready")

endmodule

bind looping_keyframe_interpolator lki_checker u_lki_checker (.*);

// ----- tb/sv/looping_keyframe_interpolator_test.sv -----
// ----------------------------------------------------------------------------
// looping_keyframe_interpolator_test
// Self-checking bench for the keyframe table and the looping pose lookup.
// A local copy of the keyframe table tracks every accepted item. It predicts
// the status, the interpolated angle and height, and the segment index of
// each result. Items go in bursts with random gaps. Between phases the loop
// length is rewritten with a new setting, from 0 and 1 up to 65535.
// ----------------------------------------------------------------------------
module looping_keyframe_interpolator_test;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int PHASE_ITEMS   = 110;
    localparam int LOOP_SETTINGS = 7;
    localparam int SETTLE_CYCLES = 40;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       start       = 1'b0;
    logic                       busy;
    lki_pkg::t_in               i_item      = '0;
    logic                       o_res_valid;
    lki_pkg::t_out              o_res;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [lki_pkg::TIME_W-1:0] i_cfg_data  = '0;

    looping_keyframe_interpolator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the block state: sorted keyframes, count, loop length.
    lki_pkg::t_key              key_tab [lki_pkg::MAX_KEYFRAMES];
    int                         key_cnt  = 0;
    logic [lki_pkg::TIME_W-1:0] loop_len = lki_pkg::LOOP_RESET;

    lki_pkg::t_in  keyframe_cmds [$];    // items waiting for the driver
    lki_pkg::t_out poses_due [$];        // predicted results, oldest first
    lki_pkg::t_out oldest_pose;

    int          mismatches = 0;
    bit          item_taken = 1'b0;
    int          burst_left = 8;
    int          gap_left   = 0;
    int unsigned cycles     = 0;

    // First stored keyframe strictly later than t, or the count if none.
    function automatic int first_later(logic [lki_pkg::TIME_W-1:0] t);
        for (int i = 0; i < key_cnt; i++) begin
            if (key_tab[i].key_time > t) return i;
        end
        return key_cnt;
    endfunction

    // Exact linear blend, truncated toward zero (SV signed divide does that).
    function automatic logic signed [lki_pkg::VAL_W-1:0] interp(longint a, longint b,
                                                                 longint off,
                                                                 longint span);
        longint num;
        num = a * span + (b - a) * off;
        return lki_pkg::VAL_W'(num / span);
    endfunction

    // Applies one item to the shadow table and returns the result it causes.
    function automatic lki_pkg::t_out next_pose(lki_pkg::t_in it);
        lki_pkg::t_out              r;
        int                         pos;
        int                         k;
        int                         tail;
        logic [lki_pkg::TIME_W-1:0] t;
        lki_pkg::t_key              lo;
        r = '0;
        t = it.time_point;
        if (it.mode == lki_pkg::MODE_INSERT) begin
            pos = first_later(t);
            r.segment_index = lki_pkg::SEG_W'(pos);
            if (key_cnt >= lki_pkg::MAX_KEYFRAMES) begin
                r.status = lki_pkg::ST_FULL;
            end else begin
                // equal times: first_later skips them, so the new key lands after
                for (int j = key_cnt; j > pos; j--) begin
                    key_tab[j] = key_tab[j - 1];
                end
                key_tab[pos].key_time = t;
                key_tab[pos].angle    = it.angle_in;
                key_tab[pos].height   = it.y_in;
                key_cnt++;
                r.status = lki_pkg::ST_OK;
            end
        end else if (key_cnt == 0) begin
            r.status = lki_pkg::ST_EMPTY;
        end else begin
            tail = key_cnt - 1;
            // loop length 0 means no wrap at all
            if (loop_len != 0) t = t % loop_len;
            k = first_later(t);
            if (k >= key_cnt) begin
                // past the last keyframe: hold its values
                r.status        = lki_pkg::ST_HOLD;
                r.rotation_out  = key_tab[tail].angle;
                r.y_out         = key_tab[tail].height;
                r.segment_index = lki_pkg::SEG_W'(tail);
            end else begin
                if (k > 0) begin
                    lo = key_tab[k - 1];
                end else begin
                    // first segment starts at time 0 with the last key's values
                    lo = key_tab[tail];
                    lo.key_time = '0;
                end
                r.status        = lki_pkg::ST_OK;
                r.rotation_out  = interp($signed(lo.angle), $signed(key_tab[k].angle),
                                         t - lo.key_time,
                                         key_tab[k].key_time - lo.key_time);
                r.y_out         = interp($signed(lo.height), $signed(key_tab[k].height),
                                         t - lo.key_time,
                                         key_tab[k].key_time - lo.key_time);
                r.segment_index = lki_pkg::SEG_W'(k);
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [lki_pkg::VAL_W-1:0] want,
                               logic [lki_pkg::VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // Rising edge: check results, then predict for the item taken at this
    // edge. Loop length writes land here too, so prediction sees them in order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken = 1'b0;
        end else begin
            if (o_res_valid) begin
                if (poses_due.size() == 0) begin
                    $error("result with no item outstanding: %p", o_res);
                    mismatches++;
                end else begin
                    oldest_pose = poses_due.pop_front();
                    check_field("status", oldest_pose.status, o_res.status);
                    check_field("rotation_out", oldest_pose.rotation_out, o_res.rotation_out);
                    check_field("y_out", oldest_pose.y_out, o_res.y_out);
                    check_field("segment_index", oldest_pose.segment_index,
                                o_res.segment_index);
                end
            end
            item_taken = start && !busy;
            if (item_taken) poses_due.push_back(next_pose(i_item));
            if (i_cfg_valid && o_cfg_ready) loop_len = i_cfg_data;
        end
    end

    // Falling edge: hold an item until taken, then send the next one. The
    // sender runs bursts of random length separated by random gaps; short and
    // long gaps both occur so they land on every stage of the block's work.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !item_taken) begin
            // still waiting for busy to drop
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
        end else if (keyframe_cmds.size() > 0) begin
            i_item <= keyframe_cmds.pop_front();
            start  <= 1'b1;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(1, 12);
            end else begin
                burst_left = burst_left - 1;
            end
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("looping_keyframe_interpolator_test NOT OK");
            $finish;
        end
    end

    task automatic queue_item(logic mode, int t, int a, int y);
        lki_pkg::t_in it;
        it.mode       = mode;
        it.time_point = lki_pkg::TIME_W'(t);
        it.angle_in   = lki_pkg::VAL_W'(a);
        it.y_in       = lki_pkg::VAL_W'(y);
        keyframe_cmds.push_back(it);
    endtask

    // Query time on or next to a stored key, often lifted by whole loops so
    // that the wrap is exercised as well.
    function automatic int near_key_time();
        int base;
        int len;
        base = int'(key_tab[$urandom_range(0, key_cnt - 1)].key_time)
             + int'($urandom_range(0, 2)) - 1;
        len  = int'(loop_len);
        if (base < 0) base = 0;
        if (base > 65535) base = 65535;
        if (len != 0 && base < len)
            base += len * int'($urandom_range(0, (65535 - base) / len));
        return base;
    endfunction

    task automatic queue_phase(int n, int insert_pct);
        int roll;
        int t;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) begin
                // keep new keys off time 0 so the first segment stays reachable;
                // once the table is full any time goes, the insert is dropped
                t = (key_cnt < lki_pkg::MAX_KEYFRAMES) ? $urandom_range(100, 65000)
                                                       : $urandom_range(0, 65535);
                queue_item(lki_pkg::MODE_INSERT, t, $urandom(), $urandom());
            end else if (roll < insert_pct + 25 || key_cnt == 0) begin
                queue_item(lki_pkg::MODE_QUERY, $urandom_range(0, 65535), $urandom(),
                           $urandom());
            end else begin
                queue_item(lki_pkg::MODE_QUERY, near_key_time(), $urandom(), $urandom());
            end
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (keyframe_cmds.size() != 0 || start || poses_due.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_loop(logic [lki_pkg::TIME_W-1:0] len);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [lki_pkg::TIME_W-1:0] new_len;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, loop length at its reset value.
        // queries on an empty table
        queue_item(lki_pkg::MODE_QUERY, 0, 0, 0);
        queue_item(lki_pkg::MODE_QUERY, 65535, -1, -1);
        // single key: first segment blends the key with itself, then hold
        queue_item(lki_pkg::MODE_INSERT, 1000, 32767, -32768);
        queue_item(lki_pkg::MODE_QUERY, 500, 0, 0);
        queue_item(lki_pkg::MODE_QUERY, 1000, 0, 0);
        // append, insert in the middle, equal time goes after, prepend
        queue_item(lki_pkg::MODE_INSERT, 40000, -32768, 32767);
        queue_item(lki_pkg::MODE_INSERT, 20000, 16'sh0100, -16'sh0100);
        queue_item(lki_pkg::MODE_INSERT, 20000, -1, 1);
        queue_item(lki_pkg::MODE_INSERT, 300, -12345, 23456);
        // time 0, inside segments, exactly on keys, and 65535, which wraps to 0
        queue_item(lki_pkg::MODE_QUERY, 0, 0, 0);
        queue_item(lki_pkg::MODE_QUERY, 150, 0, 0);
        queue_item(lki_pkg::MODE_QUERY, 19999, 0, 0);
        queue_item(lki_pkg::MODE_QUERY, 20000, 0, 0);
        queue_item(lki_pkg::MODE_QUERY, 39999, 0, 0);
        queue_item(lki_pkg::MODE_QUERY, 40000, 0, 0);
        queue_item(lki_pkg::MODE_QUERY, 65535, 0, 0);
        wait_idle();

        // Fill the table with random keys, mixed with queries; it ends full.
        queue_phase(PHASE_ITEMS, 50);
        wait_idle();

        // Query-heavy phases over a range of loop lengths; inserts now drop.
        for (int p = 0; p < LOOP_SETTINGS; p++) begin
            case (p)
                0: new_len = lki_pkg::LOOP_RESET;
                1: new_len = 16'd1;
                2: new_len = 16'd0;
                3: new_len = key_tab[key_cnt - 1].key_time;
                4: new_len = $urandom_range(2, 999);
                5: new_len = $urandom_range(1000, 65534);
                default: new_len = 16'd2;
            endcase
            write_loop(new_len);
            if (new_len == 0) begin
                // no wrap: the largest time runs past every key
                queue_item(lki_pkg::MODE_QUERY, 65535, 0, 0);
                queue_item(lki_pkg::MODE_QUERY, 0, 0, 0);
            end
            queue_phase(PHASE_ITEMS, 15);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && poses_due.size() == 0) begin
            $display("looping_keyframe_interpolator_test OK");
        end else begin
            $display("looping_keyframe_interpolator_test NOT OK");
        end
        $finish;
    end

endmodule
